/* rtl/spitr_pkg.sv */
// Shared types, codes and address decode for the SPI target register interface.
package spitr_pkg;

	localparam logic [1:0] REQ_CS_FALL = 2'd0;
	localparam logic [1:0] REQ_CS_RISE = 2'd1;
	localparam logic [1:0] REQ_BYTE    = 2'd2;
	localparam logic [1:0] REQ_UNUSED  = 2'd3;

	localparam logic [7:0] DUMMY_BYTE = 8'hAA;
	localparam int unsigned WRITE_FLAG_BIT = 7;
	localparam int unsigned NUM_SLOTS = 10;
	localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);

	typedef enum logic [1:0] {
		MODE_CMD  = 2'd0,
		MODE_WR   = 2'd1,
		MODE_RD   = 2'd2,
		MODE_IDLE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       wr_valid;
		logic [3:0] wr_addr;
		logic [7:0] wr_data;
	} rsp_t;

	function automatic logic addr_mapped(input logic [7:0] addr);
		return (addr == 8'd1) || ((addr >= 8'd6) && (addr <= 8'd14));
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] addr);
		logic [7:0] off;
		off = addr - 8'd5;
		return (addr == 8'd1) ? '0 : off[SLOT_W-1:0];
	endfunction

endpackage

/* rtl/spi_target_register_interface.sv */
// Top level: SPI target register file with auto-increment pointer.
// Takes one request word per clock while req_stall is low: chip-select fall, chip-select
// rise or received byte, and returns exactly one response word for each, registered in
// the input register, then the response register. The response register and the input
// register form a two-deep queue, so req_stall rises only when both hold a word and
// rsp_stall is high. Ten byte registers sit at addresses 1 and 6 to 14 and reset to zero;
// other addresses read as 0xAA and ignore writes. A write burst takes at most REG_LIMIT
// data bytes, and a read burst returns 0xAA once the pointer reaches REG_LIMIT.
module spi_target_register_interface #(
	parameter int unsigned REG_LIMIT = 26
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  spitr_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spitr_pkg::rsp_t   rsp
);
	import spitr_pkg::*;

	localparam int unsigned CNT_W = $clog2(REG_LIMIT + 1);
	localparam logic [7:0] PTR_LIMIT = 8'(REG_LIMIT);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(REG_LIMIT);

	logic              item_valid_s1;
	req_t              item_s1;
	logic              out_valid_q;
	rsp_t              out_q;
	logic              out_free;
	logic              s1_move;
	logic              accept;

	mode_t             mode_q, mode_d;
	logic [7:0]        ptr_q, ptr_d;
	logic [CNT_W-1:0]  wcnt_q, wcnt_d;
	logic [7:0]        regs_q [NUM_SLOTS];
	logic              wr_en;
	logic [SLOT_W-1:0] wr_slot;
	logic [7:0]        rd_addr;
	logic [7:0]        rd_byte;
	rsp_t              rsp_d;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign s1_move   = item_valid_s1 && out_free;
	assign req_stall = item_valid_s1 && !out_free;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= s1_move || (out_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			ptr_q  <= '0;
			wcnt_q <= '0;
		end else begin
			mode_q <= mode_d;
			ptr_q  <= ptr_d;
			wcnt_q <= wcnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_en) begin
			regs_q[wr_slot] <= item_s1.rx_byte;
		end
	end

	assign rd_addr = (mode_q == MODE_CMD) ? item_s1.rx_byte : ptr_q;
	assign rd_byte = addr_mapped(rd_addr) ? regs_q[slot_of(rd_addr)] : DUMMY_BYTE;
	assign wr_slot = slot_of(ptr_q);

	always_comb begin
		mode_d = mode_q;
		ptr_d  = ptr_q;
		wcnt_d = wcnt_q;
		wr_en  = 1'b0;
		rsp_d  = '0;
		if (s1_move) begin
			unique case (item_s1.req_type)
				REQ_CS_FALL: begin
					mode_d = MODE_CMD;
					wcnt_d = '0;
				end
				REQ_CS_RISE: begin
					mode_d = MODE_IDLE;
				end
				REQ_BYTE: begin
					unique case (mode_q)
						MODE_CMD: begin
							if (item_s1.rx_byte[WRITE_FLAG_BIT]) begin
								ptr_d  = {1'b0, item_s1.rx_byte[6:0]};
								wcnt_d = '0;
								mode_d = MODE_WR;
							end else begin
								rsp_d.tx_valid = 1'b1;
								rsp_d.tx_byte  = rd_byte;
								ptr_d  = item_s1.rx_byte + 8'd1;
								mode_d = MODE_RD;
							end
						end
						MODE_RD: begin
							rsp_d.tx_valid = 1'b1;
							if (ptr_q < PTR_LIMIT) begin
								rsp_d.tx_byte = rd_byte;
								ptr_d = ptr_q + 8'd1;
							end else begin
								rsp_d.tx_byte = DUMMY_BYTE;
							end
						end
						MODE_WR: begin
							if (wcnt_q < CNT_LIMIT) begin
								if (addr_mapped(ptr_q)) begin
									wr_en = 1'b1;
									rsp_d.wr_valid = 1'b1;
									rsp_d.wr_addr  = ptr_q[3:0];
									rsp_d.wr_data  = item_s1.rx_byte;
								end
								ptr_d  = ptr_q + 8'd1;
								wcnt_d = wcnt_q + CNT_W'(1);
							end
						end
						MODE_IDLE: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_wcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= CNT_LIMIT)
		else $error("write count above limit");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.tx_valid && out_q.wr_valid))
		else $error("response carries both a read and a write");

	a_wr_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.wr_valid) |->
			(out_q.wr_addr == 4'd1 || out_q.wr_addr >= 4'd6) && out_q.wr_addr <= 4'd14)
		else $error("write reported at unmapped address");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (item_valid_s1 && out_valid_q && rsp_stall))
		else $error("request stalled with room in the queue");

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> out_valid_q)
		else $error("word left input register without a response");
`endif

endmodule
